>>> rtl/msc_pkg.sv
// Shared types and constants for the merge sort block.
`default_nettype none
package msc_pkg;
   localparam int MAX_ITEMS = 64;
   localparam int ADDR_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = ADDR_W + 1;
   localparam int DATA_W = 32;
   localparam int CMP_W = 9;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last_item;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic [CMP_W-1:0]         compare_count;
      logic                     final_out;
   } rsp_type;

   // one port of a store: write and read requests
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;
endpackage
`default_nettype wire

>>> rtl/msc_ram.sv
// Single write, single read synchronous RAM with registered read data.
`default_nettype none
module msc_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

>>> rtl/msc_ctrl.sv
// Sequencer: load, top-down merge sort walked with a range stack, output.
`default_nettype none
module msc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire msc_pkg::req_type      req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output msc_pkg::rsp_type           rsp_data,
   output msc_pkg::mem_req_type       srt_req,
   input  wire logic [31:0]           srt_rdata,
   output msc_pkg::mem_req_type       scr_req,
   input  wire logic [31:0]           scr_rdata
);
   import msc_pkg::*;

   // Top-down ranges are walked with an explicit stack: each entry is a range
   // with a flag saying whether its halves are already sorted.
   typedef enum logic [3:0] {
      LOAD, POP, MRD, MRW, MCMP, MLEFT, MCPY_RD, MCPY_WR, OUT_RD, OUT_WAIT, OUT_SHOW
   } state_type;

   localparam int SP_W = ADDR_W + 2;
   localparam int STK = 2 * ADDR_W + 4;

   state_type         st_ff;
   logic [CNT_W-1:0]  n_ff;
   logic [CMP_W-1:0]  cmp_ff;
   logic [ADDR_W-1:0] lo_st [STK];
   logic [ADDR_W-1:0] hi_st [STK];
   logic              dn_st [STK];
   logic [SP_W-1:0]   sp_ff;
   logic [ADDR_W-1:0] lo_ff, mid_ff, hi_ff;
   logic [CNT_W-1:0]  i_ff, j_ff;
   logic [ADDR_W-1:0] k_ff, t_ff;
   logic [DATA_W-1:0] a_ff, b_ff;
   logic [1:0]        need_ff;   // bit0: a reload pending, bit1: b reload pending
   rsp_type           rsp_ff;
   logic              rv_ff;
   logic [ADDR_W-1:0] oi_ff;

   logic [SP_W-1:0]   top;
   logic [ADDR_W-1:0] pl, ph, pm;
   logic [ADDR_W:0]   psum;
   logic              a_lt_b;

   assign top = sp_ff - 1'b1;
   assign pl = lo_st[top[$clog2(STK)-1:0]];
   assign ph = hi_st[top[$clog2(STK)-1:0]];
   assign psum = {1'b0, pl} + {1'b0, ph};
   assign pm = psum[ADDR_W:1];
   assign a_lt_b = $signed(a_ff) < $signed(b_ff);

   assign req_ready = (st_ff == LOAD);
   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      srt_req = '0;
      scr_req = '0;
      case (st_ff)
         LOAD: begin
            srt_req.we = req_valid;
            srt_req.waddr = n_ff[ADDR_W-1:0];
            srt_req.wdata = req_data.value;
         end
         POP: srt_req.raddr = pl;
         MRD: srt_req.raddr = mid_ff + 1'b1;
         MCMP: if (need_ff == 2'b00) begin
            scr_req.we = 1'b1;
            scr_req.waddr = k_ff;
            scr_req.wdata = a_lt_b ? a_ff : b_ff;
            srt_req.raddr = a_lt_b ? i_ff[ADDR_W-1:0] + 1'b1 : j_ff[ADDR_W-1:0] + 1'b1;
         end
         MLEFT: if (need_ff == 2'b00) begin
            scr_req.we = 1'b1;
            scr_req.waddr = k_ff;
            scr_req.wdata = a_ff;
            srt_req.raddr = i_ff[ADDR_W-1:0] + 1'b1;
         end
         MCPY_RD: scr_req.raddr = t_ff;
         MCPY_WR: begin
            srt_req.we = 1'b1;
            srt_req.waddr = lo_ff + t_ff;
            srt_req.wdata = scr_rdata;
            scr_req.raddr = t_ff + 1'b1;
         end
         OUT_RD: srt_req.raddr = oi_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= LOAD;
         n_ff <= '0;
         rv_ff <= 1'b0;
         sp_ff <= '0;
      end else begin
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         case (st_ff)
            LOAD: if (req_valid) begin
               n_ff <= n_ff + 1'b1;
               if (req_data.last_item || n_ff == CNT_W'(MAX_ITEMS - 1)) begin
                  cmp_ff <= '0;
                  lo_st[0] <= '0;
                  hi_st[0] <= n_ff[ADDR_W-1:0];
                  dn_st[0] <= 1'b0;
                  sp_ff <= SP_W'(1);
                  st_ff <= POP;
               end
            end
            POP: begin
               if (sp_ff == '0) begin
                  oi_ff <= '0;
                  st_ff <= OUT_RD;
               end else if (pl >= ph) begin
                  sp_ff <= sp_ff - 1'b1;
               end else if (!dn_st[top[$clog2(STK)-1:0]]) begin
                  // push right then left so left is sorted first
                  dn_st[top[$clog2(STK)-1:0]] <= 1'b1;
                  lo_st[sp_ff[$clog2(STK)-1:0]] <= pm + 1'b1;
                  hi_st[sp_ff[$clog2(STK)-1:0]] <= ph;
                  dn_st[sp_ff[$clog2(STK)-1:0]] <= 1'b0;
                  lo_st[sp_ff[$clog2(STK)-1:0] + 1'b1] <= pl;
                  hi_st[sp_ff[$clog2(STK)-1:0] + 1'b1] <= pm;
                  dn_st[sp_ff[$clog2(STK)-1:0] + 1'b1] <= 1'b0;
                  sp_ff <= sp_ff + 2'd2;
               end else begin
                  sp_ff <= sp_ff - 1'b1;
                  lo_ff <= pl; mid_ff <= pm; hi_ff <= ph;
                  i_ff <= {1'b0, pl}; j_ff <= {1'b0, pm} + 1'b1;
                  k_ff <= '0;
                  st_ff <= MRD;
               end
            end
            MRD: begin
               a_ff <= srt_rdata;
               st_ff <= MRW;
            end
            MRW: begin
               b_ff <= srt_rdata;
               need_ff <= 2'b00;
               st_ff <= MCMP;
            end
            MCMP: begin
               if (need_ff[0]) begin
                  a_ff <= srt_rdata;
                  need_ff <= 2'b00;
               end else if (need_ff[1]) begin
                  b_ff <= srt_rdata;
                  need_ff <= 2'b00;
               end else begin
                  cmp_ff <= cmp_ff + 1'b1;
                  k_ff <= k_ff + 1'b1;
                  if (a_lt_b) begin
                     i_ff <= i_ff + 1'b1;
                     // left used up: rest of right half already sits in place
                     if (i_ff[ADDR_W-1:0] == mid_ff) begin
                        t_ff <= '0;
                        st_ff <= MCPY_RD;
                     end else need_ff <= 2'b01;
                  end else begin
                     j_ff <= j_ff + 1'b1;
                     if (j_ff[ADDR_W-1:0] == hi_ff) st_ff <= MLEFT;
                     else need_ff <= 2'b10;
                  end
               end
            end
            // right used up: move the rest of the left half without compares
            MLEFT: begin
               if (need_ff[0]) begin
                  a_ff <= srt_rdata;
                  need_ff <= 2'b00;
               end else begin
                  k_ff <= k_ff + 1'b1;
                  i_ff <= i_ff + 1'b1;
                  if (i_ff[ADDR_W-1:0] == mid_ff) begin
                     t_ff <= '0;
                     st_ff <= MCPY_RD;
                  end else need_ff <= 2'b01;
               end
            end
            MCPY_RD: st_ff <= MCPY_WR;
            MCPY_WR: begin
               t_ff <= t_ff + 1'b1;
               if (t_ff == ADDR_W'(k_ff - 1'b1)) st_ff <= POP;
            end
            OUT_RD: st_ff <= OUT_WAIT;
            OUT_WAIT: begin
               rsp_ff.sorted_value <= srt_rdata;
               rsp_ff.compare_count <= cmp_ff;
               rsp_ff.final_out <= ({1'b0, oi_ff} + 1'b1 == n_ff);
               rv_ff <= 1'b1;
               st_ff <= OUT_SHOW;
            end
            OUT_SHOW: if (rsp_ready) begin
               if ({1'b0, oi_ff} + 1'b1 == n_ff) begin
                  n_ff <= '0;
                  st_ff <= LOAD;
               end else begin
                  oi_ff <= oi_ff + 1'b1;
                  st_ff <= OUT_RD;
               end
            end
            default: st_ff <= LOAD;
         endcase
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped while stalled");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("loading while results pending");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count overflow");
endmodule
`default_nettype wire

>>> rtl/merge_sort_with_compare_count.sv
// Top level of the merge sort block.
// Values load at one request per cycle; the last one (or the 64th) starts a
// top-down merge sort held in two single-port-read RAMs. A merge starts by
// reading the first word of each half, places each word in scratch (compare
// or tail move, then the reload of the next word), and then copies the
// placed words back. Results then leave one at a time, the next one read only
// after the receiver took the last, each carrying the total compare count.
// No request is taken while sorting or emitting.
`default_nettype none
module merge_sort_with_compare_count (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire msc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output msc_pkg::rsp_type      rsp_data
);
   import msc_pkg::*;

   mem_req_type srt_req, scr_req;
   logic [DATA_W-1:0] srt_rdata, scr_rdata;

   msc_ram #(.DEPTH(MAX_ITEMS), .WIDTH(DATA_W)) u_sort (
      .clock, .we(srt_req.we), .waddr(srt_req.waddr), .wdata(srt_req.wdata),
      .raddr(srt_req.raddr), .rdata(srt_rdata));
   msc_ram #(.DEPTH(MAX_ITEMS), .WIDTH(DATA_W)) u_scr (
      .clock, .we(scr_req.we), .waddr(scr_req.waddr), .wdata(scr_req.wdata),
      .raddr(scr_req.raddr), .rdata(scr_rdata));

   msc_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .srt_req, .srt_rdata, .scr_req, .scr_rdata);
endmodule
`default_nettype wire
